[src/rct_pkg.sv]
// shared types and constants of the resp command tokenizer
package rct_pkg;

  // default width of the decoded count and length numbers
  localparam int unsigned NumberWidthDefault = 32;

  // characters with a meaning to the parser
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_INLINE,
    PH_HDR,
    PH_DOLLAR,
    PH_LEN,
    PH_BULK,
    PH_SKIP,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    NS_LEAD,
    NS_SIGN,
    NS_DIGITS,
    NS_TRAIL
  } num_stage_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TRUNCATED = 2'd1,
    STATUS_BAD_NUM   = 2'd2
  } status_e;

  // parser to number unit
  typedef struct packed {
    logic feed;
    logic clear;
  } num_ctrl_t;

  // number unit to parser
  typedef struct packed {
    logic done;
    logic bad;
    logic negative;
    logic zero;
  } num_flags_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] token_byte;
    logic       token_start;
    logic       token_end;
    logic       command_end;
    status_e    status;
  } rct_result_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

endpackage

[src/resp_command_tokenizer_top.sv]
// top level of the resp command tokenizer
//
//  channel  | dir | tdata          | tuser                             | tlast
//  ---------+-----+----------------+-----------------------------------+---------------
//  s_axis   | in  | in_byte [7:0]  | -                                 | end_of_command
//  m_axis   | out | token_byte     | byte_valid, token_start,          | command_end
//           |     |                | token_end, status[1:0]            |
//
// one word in, one word out; a new word is taken every cycle while m_axis is not stalled
// path: input register, then parse logic into the result register
// the per-word state update (phase, counters, number accumulator) is the only loop
// reset clears all parser and number state and empties both registers
// a stalled m_axis holds the result register and backs up into the input register
module resp_command_tokenizer_top #(
  parameter int unsigned NumberWidth = rct_pkg::NumberWidthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // end_of_command
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] token_byte
  output logic [4:0] m_axis_tuser_o,   // [0] byte_valid, [1] token_start, [2] token_end,
                                       // [4:3] status
  output logic       m_axis_tlast_o    // command_end
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // result register
  logic                 out_vld_q, out_vld_d;
  rct_pkg::rct_result_t out_res_q, res;

  logic                   advance;
  logic                   fire;
  logic                   s_take;
  rct_pkg::num_ctrl_t     num_ctrl;
  rct_pkg::num_flags_t    num_flags;
  logic [NumberWidth-1:0] num_acc;

  // result slot frees when empty or being taken
  assign advance         = !out_vld_q || m_axis_tready_i;
  assign fire            = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (fire) begin
      out_res_q <= res;
    end
  end

  rct_parse #(
    .NumberWidth(NumberWidth)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .num_flags_i (num_flags),
    .acc_i       (num_acc),
    .num_ctrl_o  (num_ctrl),
    .result_o    (res)
  );

  rct_number #(
    .NumberWidth(NumberWidth)
  ) u_number (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (num_ctrl),
    .byte_i  (in_byte_q),
    .flags_o (num_flags),
    .acc_o   (num_acc)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_res_q.token_byte;
  assign m_axis_tuser_o  = {out_res_q.status, out_res_q.token_end,
                            out_res_q.token_start, out_res_q.byte_valid};
  assign m_axis_tlast_o  = out_res_q.command_end;

  // a start without a byte is only the empty bulk string, which also ends
  a_empty_token_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_res_q.token_start && !out_res_q.byte_valid |-> out_res_q.token_end)
    else $error("token start without byte lacks token end");

  // truncation is only reported on the last word of a command
  a_trunc_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_res_q.status == rct_pkg::STATUS_TRUNCATED) |-> out_res_q.command_end)
    else $error("truncated status before end of command");

  // a bad number carries no token byte
  a_bad_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_res_q.status == rct_pkg::STATUS_BAD_NUM)
      |-> !out_res_q.byte_valid && !out_res_q.token_start)
    else $error("bad number result carries a token byte");

  // a held input word stays put while the result side is stalled
  a_input_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("input register lost a stalled word");

endmodule

[src/rct_number.sv]
// decimal number reader for array counts and bulk lengths
module rct_number #(
  parameter int unsigned NumberWidth = rct_pkg::NumberWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rct_pkg::num_ctrl_t     ctrl_i,
  input  logic [7:0]             byte_i,
  output rct_pkg::num_flags_t    flags_o,
  output logic [NumberWidth-1:0] acc_o
);

  localparam int unsigned ProdWidth = NumberWidth + 4;
  localparam logic [NumberWidth-1:0] MagLimit = {1'b1, {(NumberWidth-1){1'b0}}};

  rct_pkg::num_stage_e    stage_q, stage_d, stage_mid;
  logic                   neg_q, neg_d;
  logic                   seen_q, seen_d;
  logic                   ovf_q, ovf_d;
  logic                   cr_q, cr_d;
  logic [NumberWidth-1:0] acc_q, acc_d;
  logic [ProdWidth-1:0]   prod;
  logic                   too_big;
  logic                   is_digit;
  logic                   is_cr;
  logic                   crlf;

  assign is_digit = (byte_i >= rct_pkg::CharZero) && (byte_i <= rct_pkg::CharNine);
  assign is_cr    = (byte_i == rct_pkg::CharCr);
  assign crlf     = cr_q && (byte_i == rct_pkg::CharLf);

  // acc * 10 + digit
  assign prod = ProdWidth'({acc_q, 3'b000}) + ProdWidth'({acc_q, 1'b0})
              + ProdWidth'(byte_i[3:0]);
  assign too_big = prod > ProdWidth'(MagLimit);

  // a pending cr that is not followed by lf ends the digits
  assign stage_mid = (cr_q && ((stage_q == rct_pkg::NS_SIGN) ||
                               (stage_q == rct_pkg::NS_DIGITS)))
                     ? rct_pkg::NS_TRAIL : stage_q;

  always_comb begin
    stage_d = stage_q;
    neg_d   = neg_q;
    seen_d  = seen_q;
    ovf_d   = ovf_q;
    cr_d    = cr_q;
    acc_d   = acc_q;
    if (ctrl_i.clear) begin
      stage_d = rct_pkg::NS_LEAD;
      neg_d   = 1'b0;
      seen_d  = 1'b0;
      ovf_d   = 1'b0;
      cr_d    = 1'b0;
      acc_d   = '0;
    end else if (ctrl_i.feed && crlf) begin
      cr_d = 1'b0;
    end else if (ctrl_i.feed) begin
      cr_d    = is_cr;
      stage_d = stage_mid;
      if (!is_cr) begin
        priority if (stage_mid == rct_pkg::NS_TRAIL) begin
          stage_d = stage_mid;
        end else if ((stage_mid == rct_pkg::NS_LEAD) && rct_pkg::is_space(byte_i)) begin
          stage_d = stage_mid;
        end else if ((stage_mid == rct_pkg::NS_LEAD) &&
                     ((byte_i == rct_pkg::CharPlus) || (byte_i == rct_pkg::CharMinus))) begin
          neg_d   = (byte_i == rct_pkg::CharMinus);
          stage_d = rct_pkg::NS_SIGN;
        end else if (!is_digit) begin
          stage_d = rct_pkg::NS_TRAIL;
        end else begin
          stage_d = rct_pkg::NS_DIGITS;
          seen_d  = 1'b1;
          if (!ovf_q) begin
            if (too_big) begin
              ovf_d = 1'b1;
            end else begin
              acc_d = prod[NumberWidth-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= rct_pkg::NS_LEAD;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      ovf_q   <= 1'b0;
      cr_q    <= 1'b0;
      acc_q   <= '0;
    end else begin
      stage_q <= stage_d;
      neg_q   <= neg_d;
      seen_q  <= seen_d;
      ovf_q   <= ovf_d;
      cr_q    <= cr_d;
      acc_q   <= acc_d;
    end
  end

  assign flags_o.done     = ctrl_i.feed && crlf;
  assign flags_o.bad      = !seen_q || ovf_q || (!neg_q && (acc_q == MagLimit));
  assign flags_o.negative = neg_q;
  assign flags_o.zero     = (acc_q == '0);
  assign acc_o            = acc_q;

endmodule

[src/rct_parse.sv]
// command phase sequencer and token marking
module rct_parse #(
  parameter int unsigned NumberWidth = rct_pkg::NumberWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  input  rct_pkg::num_flags_t    num_flags_i,
  input  logic [NumberWidth-1:0] acc_i,
  output rct_pkg::num_ctrl_t     num_ctrl_o,
  output rct_pkg::rct_result_t   result_o
);

  rct_pkg::phase_e        phase_q, phase_d, eff_phase;
  logic [NumberWidth-1:0] elem_q, elem_d;
  logic [NumberWidth-1:0] bytes_q, bytes_d;
  logic [1:0]             skip_q, skip_d;
  logic                   open_q, open_d;

  assign eff_phase = (phase_q == rct_pkg::PH_IDLE) ? rct_pkg::PH_INLINE : phase_q;

  always_comb begin
    phase_d    = phase_q;
    elem_d     = elem_q;
    bytes_d    = bytes_q;
    skip_d     = skip_q;
    open_d     = open_q;
    num_ctrl_o = '0;
    result_o   = '0;
    result_o.command_end = last_i;
    result_o.status      = rct_pkg::STATUS_OK;
    if (fire_i) begin
      num_ctrl_o.clear = last_i;
      if ((phase_q == rct_pkg::PH_IDLE) && (byte_i == rct_pkg::CharStar)) begin
        phase_d          = rct_pkg::PH_HDR;
        num_ctrl_o.clear = 1'b1;
      end else begin
        unique case (eff_phase)
          rct_pkg::PH_INLINE: begin
            phase_d = rct_pkg::PH_INLINE;
            if (rct_pkg::is_space(byte_i)) begin
              result_o.token_end = open_q;
              open_d             = 1'b0;
            end else begin
              result_o.byte_valid  = 1'b1;
              result_o.token_byte  = byte_i;
              result_o.token_start = !open_q;
              open_d               = 1'b1;
            end
          end
          rct_pkg::PH_HDR: begin
            num_ctrl_o.feed = 1'b1;
            if (num_flags_i.done) begin
              if (num_flags_i.bad) begin
                result_o.status = rct_pkg::STATUS_BAD_NUM;
                phase_d         = rct_pkg::PH_HALT;
              end else if (!num_flags_i.negative && !num_flags_i.zero) begin
                elem_d  = acc_i;
                phase_d = rct_pkg::PH_DOLLAR;
              end else begin
                elem_d  = '0;
                phase_d = rct_pkg::PH_HALT;
              end
            end
          end
          rct_pkg::PH_DOLLAR: begin
            if (byte_i == rct_pkg::CharDollar) begin
              elem_d           = elem_q - 1'b1;
              num_ctrl_o.clear = 1'b1;
              phase_d          = rct_pkg::PH_LEN;
            end else begin
              phase_d = rct_pkg::PH_HALT;
            end
          end
          rct_pkg::PH_LEN: begin
            num_ctrl_o.feed = 1'b1;
            if (num_flags_i.done) begin
              if (num_flags_i.bad || (num_flags_i.negative && !num_flags_i.zero)) begin
                result_o.status = rct_pkg::STATUS_BAD_NUM;
                phase_d         = rct_pkg::PH_HALT;
              end else if (num_flags_i.zero) begin
                // empty bulk string
                result_o.token_start = 1'b1;
                result_o.token_end   = 1'b1;
                skip_d               = 2'd2;
                phase_d              = rct_pkg::PH_SKIP;
              end else begin
                bytes_d = acc_i;
                open_d  = 1'b0;
                phase_d = rct_pkg::PH_BULK;
                if (last_i) begin
                  result_o.status = rct_pkg::STATUS_TRUNCATED;
                end
              end
            end
          end
          rct_pkg::PH_BULK: begin
            result_o.byte_valid  = 1'b1;
            result_o.token_byte  = byte_i;
            result_o.token_start = !open_q;
            bytes_d              = bytes_q - 1'b1;
            if (bytes_q == NumberWidth'(1)) begin
              result_o.token_end = 1'b1;
              open_d             = 1'b0;
              skip_d             = 2'd2;
              phase_d            = rct_pkg::PH_SKIP;
            end else begin
              open_d = 1'b1;
              if (last_i) begin
                result_o.token_end = 1'b1;
                result_o.status    = rct_pkg::STATUS_TRUNCATED;
              end
            end
          end
          rct_pkg::PH_SKIP: begin
            skip_d = skip_q - 1'b1;
            if (skip_q == 2'd1) begin
              phase_d = (elem_q != '0) ? rct_pkg::PH_DOLLAR : rct_pkg::PH_HALT;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
      if (last_i && (phase_d == rct_pkg::PH_INLINE) && open_d) begin
        result_o.token_end = 1'b1;
      end
      if (last_i) begin
        phase_d = rct_pkg::PH_IDLE;
        elem_d  = '0;
        bytes_d = '0;
        skip_d  = '0;
        open_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rct_pkg::PH_IDLE;
      elem_q  <= '0;
      bytes_q <= '0;
      skip_q  <= '0;
      open_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      elem_q  <= elem_d;
      bytes_q <= bytes_d;
      skip_q  <= skip_d;
      open_q  <= open_d;
    end
  end

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for the resp command tokenizer: directed table, then random commands
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod     = 20;
  localparam int TimeoutCycles = 200000;
  localparam int RandomWords   = 900;
  localparam int NumWidth      = rct_pkg::NumberWidthDefault;
  localparam logic [63:0] NumLimit = 64'd1 << (NumWidth - 1);

  typedef struct {
    logic                 ch;
    logic                 last;
    logic                 typed;
    rct_pkg::rct_result_t want;
  } row_dummy_t;

  typedef struct {
    logic [7:0]           ch;
    logic                 last;
    logic                 typed;
    rct_pkg::rct_result_t want;
  } row_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;
  logic       s_axis_tlast_i  = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;   // [7:0] token_byte
  logic [4:0] m_axis_tuser_o;   // [0] byte_valid, [1] token_start, [2] token_end, [4:3] status
  logic       m_axis_tlast_o;

  resp_command_tokenizer_top dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // predicted token words, oldest first
  rct_pkg::rct_result_t expected_tokens[$];
  row_t                 directed_rows[$];
  logic [7:0]           cmd_text[$];

  int   fails      = 0;
  int   words_in   = 0;   // every accepted input word
  int   live_words = 0;   // accepted words that the parser did not ignore
  logic steady     = 1'b0;
  logic halted_word;

  // predictor state
  rct_pkg::phase_e     cur_phase;
  logic [63:0]         arr_left;
  logic [63:0]         bulk_left;
  logic [63:0]         acc;
  logic                acc_neg;
  logic [1:0]          skip_left;
  logic                in_token;
  rct_pkg::num_stage_e nstage;
  logic                saw_digit;
  logic                too_big;
  logic                cr_seen;

  function automatic logic blank(logic [7:0] c);
    return (c == rct_pkg::CharSpace) || (c >= rct_pkg::CharTab && c <= rct_pkg::CharCr);
  endfunction

  function automatic void clear_number();
    acc       = '0;
    acc_neg   = 1'b0;
    nstage    = rct_pkg::NS_LEAD;
    saw_digit = 1'b0;
    too_big   = 1'b0;
    cr_seen   = 1'b0;
  endfunction

  function automatic void restart_parser();
    cur_phase = rct_pkg::PH_IDLE;
    arr_left  = '0;
    bulk_left = '0;
    skip_left = '0;
    in_token  = 1'b0;
    clear_number();
  endfunction

  // one character of number text, cr lf handling already done
  function automatic void digest_char(logic [7:0] c);
    logic [63:0] d;
    d = 64'(c) - 64'(rct_pkg::CharZero);
    if (nstage != rct_pkg::NS_TRAIL && !(nstage == rct_pkg::NS_LEAD && blank(c))) begin
      if (nstage == rct_pkg::NS_LEAD && (c == rct_pkg::CharPlus || c == rct_pkg::CharMinus))
      begin
        acc_neg = (c == rct_pkg::CharMinus);
        nstage  = rct_pkg::NS_SIGN;
      end else if (c < rct_pkg::CharZero || c > rct_pkg::CharNine) begin
        nstage = rct_pkg::NS_TRAIL;
      end else begin
        nstage    = rct_pkg::NS_DIGITS;
        saw_digit = 1'b1;
        if (!too_big) begin
          if (acc > (NumLimit - d) / 64'd10) too_big = 1'b1;
          else acc = acc * 64'd10 + d;
        end
      end
    end
  endfunction

  // true once cr lf closes the number; a lone cr counts as text
  function automatic logic number_byte(logic [7:0] c);
    logic done;
    done = 1'b0;
    if (cr_seen && c == rct_pkg::CharLf) begin
      cr_seen = 1'b0;
      done    = 1'b1;
    end else begin
      if (cr_seen) digest_char(rct_pkg::CharCr);
      cr_seen = (c == rct_pkg::CharCr);
      if (!cr_seen) digest_char(c);
    end
    return done;
  endfunction

  function automatic logic number_bad();
    return !saw_digit || too_big || (!acc_neg && acc == NumLimit);
  endfunction

  function automatic rct_pkg::rct_result_t tokenize_byte(logic [7:0] c, logic last);
    rct_pkg::rct_result_t r;
    logic                 taken;
    r           = '0;
    taken       = 1'b0;
    halted_word = (cur_phase == rct_pkg::PH_HALT);
    if (cur_phase == rct_pkg::PH_IDLE) begin
      if (c == rct_pkg::CharStar) begin
        cur_phase = rct_pkg::PH_HDR;
        clear_number();
        taken = 1'b1;
      end else begin
        cur_phase = rct_pkg::PH_INLINE;
      end
    end
    if (!taken) begin
      case (cur_phase)
        rct_pkg::PH_INLINE: begin
          if (blank(c)) begin
            if (in_token) begin
              r.token_end = 1'b1;
              in_token    = 1'b0;
            end
          end else begin
            r.byte_valid  = 1'b1;
            r.token_byte  = c;
            r.token_start = !in_token;
            in_token      = 1'b1;
          end
        end
        rct_pkg::PH_HDR: begin
          if (number_byte(c)) begin
            if (number_bad()) begin
              r.status  = rct_pkg::STATUS_BAD_NUM;
              cur_phase = rct_pkg::PH_HALT;
            end else begin
              // a negative count reads no elements
              arr_left  = acc_neg ? 64'd0 : acc;
              cur_phase = (arr_left != 0) ? rct_pkg::PH_DOLLAR : rct_pkg::PH_HALT;
            end
          end
        end
        rct_pkg::PH_DOLLAR: begin
          if (c == rct_pkg::CharDollar) begin
            arr_left = arr_left - 64'd1;
            clear_number();
            cur_phase = rct_pkg::PH_LEN;
          end else begin
            cur_phase = rct_pkg::PH_HALT;
          end
        end
        rct_pkg::PH_LEN: begin
          if (number_byte(c)) begin
            if (number_bad() || (acc_neg && acc != 0)) begin
              r.status  = rct_pkg::STATUS_BAD_NUM;
              cur_phase = rct_pkg::PH_HALT;
            end else if (acc == 0) begin
              r.token_start = 1'b1;
              r.token_end   = 1'b1;
              skip_left     = 2'd2;
              cur_phase     = rct_pkg::PH_SKIP;
            end else begin
              bulk_left = acc;
              in_token  = 1'b0;
              cur_phase = rct_pkg::PH_BULK;
              if (last) r.status = rct_pkg::STATUS_TRUNCATED;
            end
          end
        end
        rct_pkg::PH_BULK: begin
          r.byte_valid  = 1'b1;
          r.token_byte  = c;
          r.token_start = !in_token;
          bulk_left     = bulk_left - 64'd1;
          if (bulk_left == 0) begin
            r.token_end = 1'b1;
            in_token    = 1'b0;
            skip_left   = 2'd2;
            cur_phase   = rct_pkg::PH_SKIP;
          end else begin
            in_token = 1'b1;
            if (last) begin
              r.token_end = 1'b1;
              r.status    = rct_pkg::STATUS_TRUNCATED;
            end
          end
        end
        rct_pkg::PH_SKIP: begin
          skip_left = skip_left - 2'd1;
          if (skip_left == 0)
            cur_phase = (arr_left != 0) ? rct_pkg::PH_DOLLAR : rct_pkg::PH_HALT;
        end
        default: begin
        end
      endcase
    end
    if (last && cur_phase == rct_pkg::PH_INLINE && in_token) r.token_end = 1'b1;
    r.command_end = last;
    if (last) restart_parser();
    return r;
  endfunction

  function automatic rct_pkg::rct_result_t outcome(logic v, logic [7:0] b, logic s, logic e,
                                                   logic c, rct_pkg::status_e st);
    rct_pkg::rct_result_t r;
    r.byte_valid  = v;
    r.token_byte  = b;
    r.token_start = s;
    r.token_end   = e;
    r.command_end = c;
    r.status      = st;
    return r;
  endfunction

  task automatic add_row(input logic [7:0] ch, input logic last, input logic typed,
                         input rct_pkg::rct_result_t want);
    row_t row;
    row.ch        = ch;
    row.last      = last;
    row.typed     = typed;
    row.want      = want;
    directed_rows = {directed_rows, row};
  endtask

  // offer one word, now and then after a random gap, and log its prediction once taken
  task automatic send_word(input logic [7:0] ch, input logic last, input logic typed,
                           input rct_pkg::rct_result_t want);
    rct_pkg::rct_result_t r;
    if (!steady && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = tokenize_byte(ch, last);
    if (typed) expected_tokens = {expected_tokens, want};
    else expected_tokens = {expected_tokens, r};
    words_in++;
    if (!halted_word) live_words++;
  endtask

  task automatic check_word();
    rct_pkg::rct_result_t want;
    if (expected_tokens.size() == 0) begin
      $error("result word with nothing expected");
      fails++;
    end else begin
      want = expected_tokens.pop_front();
      if (m_axis_tuser_o[0] !== want.byte_valid) begin
        $error("byte_valid: expected %0d, got %0d", want.byte_valid, m_axis_tuser_o[0]);
        fails++;
      end
      if (m_axis_tdata_o !== want.token_byte) begin
        $error("token_byte: expected %02h, got %02h", want.token_byte, m_axis_tdata_o);
        fails++;
      end
      if (m_axis_tuser_o[1] !== want.token_start) begin
        $error("token_start: expected %0d, got %0d", want.token_start, m_axis_tuser_o[1]);
        fails++;
      end
      if (m_axis_tuser_o[2] !== want.token_end) begin
        $error("token_end: expected %0d, got %0d", want.token_end, m_axis_tuser_o[2]);
        fails++;
      end
      if (m_axis_tlast_o !== want.command_end) begin
        $error("command_end: expected %0d, got %0d", want.command_end, m_axis_tlast_o);
        fails++;
      end
      if (m_axis_tuser_o[4:3] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o[4:3]);
        fails++;
      end
    end
  endtask

  // command text builders
  task automatic add_byte(input logic [7:0] c);
    cmd_text = {cmd_text, c};
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic put_crlf();
    add_byte(rct_pkg::CharCr);
    add_byte(rct_pkg::CharLf);
  endtask

  task automatic put_random(input int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  // number text with the odd leading blank, plus sign or trailing junk
  task automatic put_number(input string digits);
    if ($urandom_range(0, 7) == 0)
      add_byte($urandom_range(0, 1) ? rct_pkg::CharSpace : rct_pkg::CharTab);
    if ($urandom_range(0, 7) == 0 && !(digits.len() > 0 && digits[0] == rct_pkg::CharMinus))
      add_byte(rct_pkg::CharPlus);
    put_text(digits);
    case ($urandom_range(0, 11))
      0: put_text("x");
      1: add_byte(rct_pkg::CharCr);   // lone cr before the real cr lf
      2: add_byte(rct_pkg::CharSpace);
      default: begin
      end
    endcase
    put_crlf();
  endtask

  function automatic logic [7:0] inline_char();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 5) == 5) ? rct_pkg::CharSpace
                                            : 8'(rct_pkg::CharTab + $urandom_range(0, 4));
      1, 2: return 8'(8'h61 + $urandom_range(0, 25));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_array();
    int n;
    int len;
    n = $urandom_range(1, 4);
    add_byte(rct_pkg::CharStar);
    // now and then the header claims one element more than follows
    put_number($sformatf("%0d", n + ($urandom_range(0, 5) == 0)));
    for (int k = 0; k < n; k++) begin
      add_byte(rct_pkg::CharDollar);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      put_number($sformatf("%0d", len));
      put_random(len);
      if ($urandom_range(0, 9) == 0) put_random(2);
      else put_crlf();
    end
    if ($urandom_range(0, 5) == 0) put_random($urandom_range(1, 4));
  endtask

  task automatic make_command();
    int   kind;
    int   keep;
    logic [7:0] b;
    cmd_text.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 12)) add_byte(inline_char());
    end else if (kind < 20) begin
      put_random($urandom_range(1, 8));
    end else if (kind < 70) begin
      put_array();
    end else if (kind < 85) begin
      // array cut short at a random point (or kept whole)
      put_array();
      keep = $urandom_range(1, cmd_text.size());
      while (cmd_text.size() > keep) void'(cmd_text.pop_back());
    end else if (kind < 95) begin
      add_byte(rct_pkg::CharStar);
      if ($urandom_range(0, 1) == 1) begin
        put_text("1");
        put_crlf();
        add_byte(rct_pkg::CharDollar);
      end
      case ($urandom_range(0, 7))
        0: put_number("");
        1: put_number("abc");
        2: put_number("2147483648");
        3: put_number("-2147483648");
        4: put_number("99999999999");
        5: put_number($sformatf("-%0d", $urandom_range(0, 9)));
        6: begin
          put_text("1");
          add_byte(rct_pkg::CharCr);
          put_text("2");
          put_crlf();
        end
        default: put_number("2147483647");
      endcase
      put_random($urandom_range(0, 5));
    end else begin
      // element without its dollar sign
      add_byte(rct_pkg::CharStar);
      put_number($sformatf("%0d", $urandom_range(1, 3)));
      b = 8'($urandom_range(0, 255));
      if (b == rct_pkg::CharDollar) b = 8'h25;
      add_byte(b);
      put_random($urandom_range(0, 4));
    end
  endtask

  // result side: checks each taken word and paces tready
  initial begin
    int   hold_left;
    logic held;
    hold_left = 0;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) check_word();
      // one long back-pressure stretch to fill the pipeline and stall the input
      if (!held && words_in >= 250) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // stimulus side
  initial begin
    logic paused;
    paused = 1'b0;
    restart_parser();

    // extremes of the byte as inline tokens, ended on the last byte and on a blank
    add_row(8'hFF, 1'b1, 1'b1,
            outcome(1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, rct_pkg::STATUS_OK));
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharSpace, 1'b1, 1'b1,
            outcome(1'b0, 8'h00, 1'b0, 1'b1, 1'b1, rct_pkg::STATUS_OK));
    // two elements: an empty bulk string, then a negative length
    add_row(rct_pkg::CharStar, 1'b0, 1'b1,
            outcome(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, rct_pkg::STATUS_OK));
    add_row("2", 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharCr, 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharLf, 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharDollar, 1'b0, 1'b0, '0);
    add_row("0", 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharCr, 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharLf, 1'b0, 1'b1,
            outcome(1'b0, 8'h00, 1'b1, 1'b1, 1'b0, rct_pkg::STATUS_OK));
    add_row("p", 1'b0, 1'b0, '0);
    add_row("q", 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharDollar, 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharMinus, 1'b0, 1'b0, '0);
    add_row("1", 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharCr, 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharLf, 1'b1, 1'b1,
            outcome(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, rct_pkg::STATUS_BAD_NUM));
    // bulk string cut short by the end of the command
    add_row(rct_pkg::CharStar, 1'b0, 1'b0, '0);
    add_row("1", 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharCr, 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharLf, 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharDollar, 1'b0, 1'b0, '0);
    add_row("3", 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharCr, 1'b0, 1'b0, '0);
    add_row(rct_pkg::CharLf, 1'b0, 1'b0, '0);
    add_row("k", 1'b1, 1'b1,
            outcome(1'b1, "k", 1'b1, 1'b1, 1'b1, rct_pkg::STATUS_TRUNCATED));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);

    live_words = 0;
    while (live_words < RandomWords) begin
      make_command();
      // sender pauses once until the pipeline has drained
      if (!paused && live_words >= 700) begin
        paused = 1'b1;
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        while (expected_tokens.size() != 0) @(posedge clk_i);
      end
      foreach (cmd_text[i]) begin
        steady = (live_words >= 450 && live_words < 600);
        send_word(cmd_text[i], i == cmd_text.size() - 1, 1'b0, '0);
      end
    end
    s_axis_tvalid_i <= 1'b0;
    steady = 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
src/rct_pkg.sv
src/rct_number.sv
src/rct_parse.sv
src/resp_command_tokenizer_top.sv
tb/sv/testbench.sv
